### design/sbrle_pkg.sv
// Shared types, constants and the six-bit alphabet for the six-bit text / RLE90 decoder.
// No dependencies; imported by sbrle_symmap and sixbit_rle90_text_decoder.
`default_nettype none

package sbrle_pkg;

  // Width of the per-stream packed and decoded byte counters.
  localparam int COUNT_BITS = 28;
  // Width of the limit register and of the decoded_total output field.
  localparam int LIMIT_W    = 28;
  localparam int TOTAL_W    = 28;
  // Compare width: wide enough for either count plus one carry bit.
  localparam int CMP_W      = ((COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W) + 1;

  localparam logic [CMP_W-1:0]   CNT_MAX_EXT  = (CMP_W'(1) << COUNT_BITS) - CMP_W'(1);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = LIMIT_W'(134217728);

  localparam logic [7:0] RLE_MARK   = 8'h90;
  localparam logic [7:0] CLOSE_CHAR = 8'h3A;
  localparam logic [3:0] GROUP_BITS = 4'd6;
  localparam logic [3:0] BYTE_BITS  = 4'd8;
  localparam logic [2:0] MIN_GROUPS = 3'd4;

  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_CR  = 8'h0D;
  localparam logic [7:0] CH_SP  = 8'h20;

  // Alphabet, index = six-bit value.
  localparam logic [7:0] SYM_TABLE [64] = '{
    8'h21, 8'h22, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h28,
    8'h29, 8'h2A, 8'h2B, 8'h2C, 8'h2D, 8'h30, 8'h31, 8'h32,
    8'h33, 8'h34, 8'h35, 8'h36, 8'h38, 8'h39, 8'h40, 8'h41,
    8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49,
    8'h4A, 8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52,
    8'h53, 8'h54, 8'h55, 8'h56, 8'h58, 8'h59, 8'h5A, 8'h5B,
    8'h60, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h68,
    8'h69, 8'h6A, 8'h6B, 8'h6C, 8'h6D, 8'h70, 8'h71, 8'h72
  };

  typedef enum logic [2:0] {
    ST_RUN      = 3'd0,
    ST_DONE     = 3'd1,
    ST_TRUNC    = 3'd2,
    ST_BADCHAR  = 3'd3,
    ST_FEW      = 3'd4,
    ST_BADCOUNT = 3'd5,
    ST_DANGLE   = 3'd6,
    ST_LIMIT    = 3'd7
  } status_t;

  typedef struct packed {
    logic       is_sym;
    logic       is_blank;
    logic       is_colon;
    logic [5:0] sextet;
  } sym_class_t;

endpackage

`default_nettype wire

### design/sbrle_symmap.sv
// Character classifier: alphabet lookup, whitespace and close-character detect.
// Depends on sbrle_pkg.
`default_nettype none

module sbrle_symmap (
  input  logic [7:0]             in_char,
  output sbrle_pkg::sym_class_t  cls
);
  import sbrle_pkg::*;

  always_comb begin
    cls = '0;
    for (int i = 0; i < 64; i++) begin
      if (SYM_TABLE[i] == in_char) begin
        cls.is_sym = 1'b1;
        cls.sextet = 6'(i);
      end
    end
    cls.is_blank = in_char inside {CH_TAB, CH_LF, CH_CR, CH_SP};
    cls.is_colon = (in_char == CLOSE_CHAR);
  end

endmodule

`default_nettype wire

### design/sixbit_rle90_text_decoder.sv
// Top level: six-bit text unpacker with RLE90 run decode and stream status.
// Depends on sbrle_pkg and sbrle_symmap.
//
//   port group   dir  handshake          payload
//   in           in   in_valid/in_stall  in_char, is_end
//   out          out  out_valid/out_stall status, byte_value, run_length, decoded_total,
//                                        sextet_remainder, tail_zeros, last
//   cfg          in   cfg_we             cfg_wdata (decoded_limit)
//
// One request per cycle sustained while out_stall is low. A request lands in the input
// register, is decoded in one pass against the stream state, and its result (if any)
// goes to the output register, which raises out_valid.
// Reset (rst, synchronous) clears all stream state and sets the limit to 2^27.
// out_stall holds the output register; in_stall rises only while the input register
// is full and the output register cannot take a new result.
`default_nettype none

module sixbit_rle90_text_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_char,
  input  logic                          is_end,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sbrle_pkg::status_t            status,
  output logic [7:0]                    byte_value,
  output logic [7:0]                    run_length,
  output logic [sbrle_pkg::TOTAL_W-1:0] decoded_total,
  output logic [1:0]                    sextet_remainder,
  output logic [1:0]                    tail_zeros,
  output logic                          last,
  input  logic                          cfg_we,
  input  logic [sbrle_pkg::LIMIT_W-1:0] cfg_wdata
);
  import sbrle_pkg::*;

  // input register
  logic       in_q_valid;
  logic [7:0] in_q_char;
  logic       in_q_end;
  logic       out_ok;
  logic       fire;
  sym_class_t cls;

  // config
  logic [LIMIT_W-1:0] decoded_limit;
  logic [CMP_W-1:0]   lim;

  // stream state
  logic [5:0]            bit_store, bit_store_next;
  logic [2:0]            bit_fill, bit_fill_next;
  logic [2:0]            group_count, group_count_next;
  logic [1:0]            group_phase, group_phase_next;
  logic [7:0]            prior_byte, prior_byte_next;
  logic                  prior_valid, prior_valid_next;
  logic                  marker_pending, marker_pending_next;
  logic [COUNT_BITS-1:0] packed_count, packed_count_next;
  logic [COUNT_BITS-1:0] output_count, output_count_next;
  logic [1:0]            zero_tail, zero_tail_next;
  logic                  stream_closed, stream_closed_next;

  // result
  logic               res_valid;
  status_t            res_status;
  logic [7:0]         res_byte;
  logic [7:0]         res_len;
  logic [TOTAL_W-1:0] res_total;
  logic [1:0]         res_rem;
  logic [1:0]         res_zt;
  logic               res_last;

  assign out_ok   = !out_valid || !out_stall;
  assign in_stall = in_q_valid && !out_ok;
  assign fire     = in_q_valid && out_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (!in_stall) begin
      in_q_valid <= in_valid;
    end
    if (!in_stall && in_valid) begin
      in_q_char <= in_char;
      in_q_end  <= is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decoded_limit <= LIMIT_RESET;
    end else if (cfg_we) begin
      decoded_limit <= cfg_wdata;
    end
  end

  assign lim = (CMP_W'(decoded_limit) < CNT_MAX_EXT) ? CMP_W'(decoded_limit) : CNT_MAX_EXT;

  sbrle_symmap u_symmap (
    .in_char (in_q_char),
    .cls     (cls)
  );

  always_comb begin
    logic [3:0]       fill_sum;
    logic [2:0]       fill_left;
    logic [11:0]      total;
    logic [7:0]       pb;
    logic [CMP_W-1:0] oc_sum;
    logic             do_emit;
    logic [7:0]       emit_val;
    logic [7:0]       emit_rep;
    logic             do_finish;
    status_t          fin_status;
    logic             fin_close;

    bit_store_next      = bit_store;
    bit_fill_next       = bit_fill;
    group_count_next    = group_count;
    group_phase_next    = group_phase;
    prior_byte_next     = prior_byte;
    prior_valid_next    = prior_valid;
    marker_pending_next = marker_pending;
    packed_count_next   = packed_count;
    output_count_next   = output_count;
    zero_tail_next      = zero_tail;
    stream_closed_next  = stream_closed;

    fill_sum   = '0;
    fill_left  = '0;
    total      = '0;
    pb         = '0;
    oc_sum     = '0;
    do_emit    = 1'b0;
    emit_val   = '0;
    emit_rep   = '0;
    do_finish  = 1'b0;
    fin_status = ST_DONE;
    fin_close  = 1'b0;

    res_valid  = 1'b0;
    res_status = ST_RUN;
    res_byte   = '0;
    res_len    = '0;
    res_total  = '0;
    res_rem    = '0;
    res_zt     = '0;
    res_last   = 1'b0;

    if (fire) begin
      if (in_q_end) begin
        if (stream_closed) begin
          stream_closed_next = 1'b0;
        end else begin
          do_finish  = 1'b1;
          fin_status = (group_count < MIN_GROUPS) ? ST_FEW : ST_TRUNC;
        end
      end else if (!stream_closed) begin
        if (cls.is_colon) begin
          do_finish = 1'b1;
          fin_close = 1'b1;
          if (group_count < MIN_GROUPS) begin
            fin_status = ST_FEW;
          end else if (marker_pending) begin
            fin_status = ST_DANGLE;
          end else begin
            fin_status = ST_DONE;
          end
        end else if (!cls.is_sym) begin
          if (!cls.is_blank) begin
            do_finish  = 1'b1;
            fin_close  = 1'b1;
            fin_status = ST_BADCHAR;
          end
        end else begin
          if (group_count < MIN_GROUPS) begin
            group_count_next = group_count + 3'd1;
          end
          group_phase_next = group_phase + 2'd1;
          total    = {bit_store, cls.sextet};
          fill_sum = {1'b0, bit_fill} + GROUP_BITS;
          if (fill_sum < BYTE_BITS) begin
            bit_store_next = total[5:0];
            bit_fill_next  = fill_sum[2:0];
          end else begin
            fill_left      = 3'(fill_sum - BYTE_BITS);
            pb             = 8'(total >> fill_left);
            bit_store_next = 6'(total & ((12'd1 << fill_left) - 12'd1));
            bit_fill_next  = fill_left;
            if (CMP_W'(packed_count) >= lim) begin
              do_finish  = 1'b1;
              fin_close  = 1'b1;
              fin_status = ST_LIMIT;
            end else begin
              packed_count_next = packed_count + COUNT_BITS'(1);
              if (marker_pending) begin
                marker_pending_next = 1'b0;
                if (pb == 8'd0) begin
                  // escaped literal marker byte
                  do_emit  = 1'b1;
                  emit_val = RLE_MARK;
                  emit_rep = 8'd1;
                end else if (pb == 8'd1 || !prior_valid) begin
                  do_finish  = 1'b1;
                  fin_close  = 1'b1;
                  fin_status = ST_BADCOUNT;
                end else begin
                  do_emit  = 1'b1;
                  emit_val = prior_byte;
                  emit_rep = pb - 8'd1;
                end
              end else if (pb == RLE_MARK) begin
                marker_pending_next = 1'b1;
              end else begin
                do_emit  = 1'b1;
                emit_val = pb;
                emit_rep = 8'd1;
              end
            end
          end
        end
      end
    end

    if (do_emit) begin
      oc_sum = CMP_W'(output_count) + CMP_W'(emit_rep);
      if (oc_sum > lim) begin
        do_finish  = 1'b1;
        fin_close  = 1'b1;
        fin_status = ST_LIMIT;
      end else begin
        output_count_next = oc_sum[COUNT_BITS-1:0];
        if (emit_val == 8'd0) begin
          zero_tail_next = (emit_rep > 8'd1 || zero_tail != 2'd0) ? 2'd2 : 2'd1;
        end else begin
          zero_tail_next = 2'd0;
        end
        prior_byte_next  = emit_val;
        prior_valid_next = 1'b1;
        res_valid  = 1'b1;
        res_status = ST_RUN;
        res_byte   = emit_val;
        res_len    = emit_rep;
        res_total  = oc_sum[TOTAL_W-1:0];
      end
    end

    if (do_finish) begin
      // status reports the phase as updated by this character
      res_valid  = 1'b1;
      res_status = fin_status;
      res_byte   = '0;
      res_len    = '0;
      res_total  = TOTAL_W'(CMP_W'(output_count));
      res_rem    = group_phase_next;
      res_zt     = zero_tail;
      res_last   = 1'b1;

      bit_store_next      = '0;
      bit_fill_next       = '0;
      group_count_next    = '0;
      group_phase_next    = '0;
      prior_byte_next     = '0;
      prior_valid_next    = 1'b0;
      marker_pending_next = 1'b0;
      packed_count_next   = '0;
      output_count_next   = '0;
      zero_tail_next      = '0;
      stream_closed_next  = fin_close;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_store      <= '0;
      bit_fill       <= '0;
      group_count    <= '0;
      group_phase    <= '0;
      prior_byte     <= '0;
      prior_valid    <= 1'b0;
      marker_pending <= 1'b0;
      packed_count   <= '0;
      output_count   <= '0;
      zero_tail      <= '0;
      stream_closed  <= 1'b0;
    end else begin
      bit_store      <= bit_store_next;
      bit_fill       <= bit_fill_next;
      group_count    <= group_count_next;
      group_phase    <= group_phase_next;
      prior_byte     <= prior_byte_next;
      prior_valid    <= prior_valid_next;
      marker_pending <= marker_pending_next;
      packed_count   <= packed_count_next;
      output_count   <= output_count_next;
      zero_tail      <= zero_tail_next;
      stream_closed  <= stream_closed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ok) begin
      out_valid <= fire && res_valid;
    end
    if (fire && res_valid) begin
      status           <= res_status;
      byte_value       <= res_byte;
      run_length       <= res_len;
      decoded_total    <= res_total;
      sextet_remainder <= res_rem;
      tail_zeros       <= res_zt;
      last             <= res_last;
    end
  end

  // bit fill only ever holds 0, 2, 4 or 6 leftover bits
  a_fill_even: assert property (@(posedge clk) disable iff (rst) !bit_fill[0])
    else $error("odd bit fill");

  // a stream only closes together with a final status result
  a_close_reports: assert property (@(posedge clk) disable iff (rst)
    $rose(stream_closed) |-> out_valid && last)
    else $error("stream closed without final status");

  // run results carry a nonzero length, status results none
  a_run_len: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((status == ST_RUN) == !last) && ((run_length != 8'd0) == !last))
    else $error("result kind mismatch");

  // no pending marker without a packed byte behind it
  a_marker_count: assert property (@(posedge clk) disable iff (rst)
    marker_pending |-> packed_count != '0)
    else $error("marker pending with empty stream");

  // a run never takes the total past the limit in force when it was decoded
  a_total_limit: assert property (@(posedge clk) disable iff (rst)
    (output_count != $past(output_count)) |-> (CMP_W'(output_count) <= $past(lim)))
    else $error("decoded count beyond limit");

endmodule

`default_nettype wire
